### design/wtt_pkg.sv
// shared types and constants for the wrapped tick to timeval converter
`timescale 1ns / 1ps

package wtt_pkg;

  localparam int unsigned RateW = 31;
  localparam int unsigned WordW = 32;
  localparam int unsigned UsecW = 20;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned AddrW = 3;

  localparam logic [RateW-1:0] RateReset = 31'd1000000;
  localparam logic [UsecW-1:0] UsecPerSec = 20'd1000000;

  // register indexes, taken from paddr[2]
  localparam logic RegTickRate = 1'b0;

  // payload that rides alongside a division
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic             flag;
  } side_t;

endpackage

### design/wrapped_ticks_to_timeval.sv
// top level: wrapping tick count plus seconds hint to seconds and microseconds
`timescale 1ns / 1ps

// One item enters per clock while the output is not stalled, and its result
// leaves through three 32-stage divider pipelines (step-back count, whole
// seconds, rounded microseconds) plus six multiply/add stages. Sustained
// throughput is one transfer per cycle while the output is not stalled; a
// stall on the output freezes the whole pipeline and stalls the input.
// tick_rate may only be written while no item is in flight; zero acts as one.

module wrapped_ticks_to_timeval (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtt_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   tick_count,
  input  logic [31:0]                   hint_seconds,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   seconds,
  output logic [19:0]                   microseconds
);

  logic [wtt_pkg::RateW-1:0] tick_rate;
  logic [wtt_pkg::RateW-1:0] rate_eff;
  logic                      adv;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= wtt_pkg::RateReset;
    end else if (psel && penable && pwrite && paddr[2] == wtt_pkg::RegTickRate) begin
      tick_rate <= pwdata[wtt_pkg::RateW-1:0];
    end
  end
  assign prdata   = (paddr[2] == wtt_pkg::RegTickRate) ? {1'b0, tick_rate} : 32'd0;
  assign rate_eff = (tick_rate == '0) ? 31'd1 : tick_rate;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 0: base = hint * rate
  logic        p0_v;
  logic [31:0] p0_ticks, p0_secs, p0_prod;
  logic [62:0] mul0;
  assign mul0 = hint_seconds * rate_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
    end else if (adv) begin
      p0_v <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_ticks <= tick_count;
      p0_secs  <= hint_seconds;
      p0_prod  <= mul0[31:0];
    end
  end

  // step-back count from the negative difference
  logic [31:0]    delta0;
  wtt_pkg::side_t a_side_in, a_side_out;
  logic           a_v;
  logic [31:0]    a_q;
  logic [30:0]    a_r;
  assign delta0    = p0_ticks - p0_prod;
  assign a_side_in = '{a: p0_ticks, b: p0_secs, flag: delta0[31]};

  wtt_div_pipe u_div_back (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (p0_v),
    .rem_init ('0),
    .num      ({1'b0, ~delta0[30:0]}),
    .divisor  (rate_eff),
    .side_in  (a_side_in),
    .out_valid(a_v),
    .quot     (a_q),
    .rem      (a_r),
    .side_out (a_side_out)
  );

  // adjusted seconds, then its base
  logic        s1_v, s2_v;
  logic [31:0] s1_ticks, s1_secs, s2_ticks, s2_secs, s2_prod;
  logic [62:0] mul1;
  assign mul1 = s1_secs * rate_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s1_v <= a_v;
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ticks <= a_side_out.a;
      s1_secs  <= a_side_out.flag ? a_side_out.b - (a_q + 32'd1) : a_side_out.b;
      s2_ticks <= s1_ticks;
      s2_secs  <= s1_secs;
      s2_prod  <= mul1[31:0];
    end
  end

  // whole seconds and remainder of the difference
  wtt_pkg::side_t b_side_in, b_side_out;
  logic           b_v;
  logic [31:0]    b_q;
  logic [30:0]    b_r;
  assign b_side_in = '{a: s2_secs, b: '0, flag: 1'b0};

  wtt_div_pipe u_div_whole (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s2_v),
    .rem_init ('0),
    .num      (s2_ticks - s2_prod),
    .divisor  (rate_eff),
    .side_in  (b_side_in),
    .out_valid(b_v),
    .quot     (b_q),
    .rem      (b_r),
    .side_out (b_side_out)
  );

  // remainder scaled to microseconds plus half a microsecond for rounding
  logic        r1_v, r2_v;
  logic [31:0] r1_secs, r2_secs;
  logic [50:0] r1_mul;
  logic [51:0] r2_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
    end else if (adv) begin
      r1_v <= b_v;
      r2_v <= r1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r1_secs <= b_side_out.a + b_q;
      r1_mul  <= b_r * wtt_pkg::UsecPerSec;
      r2_secs <= r1_secs;
      r2_frac <= {1'b0, r1_mul} + {22'd0, rate_eff[30:1]};
    end
  end

  // quotient is below 2^20, so the upper bits already sit below the divisor
  wtt_pkg::side_t c_side_in, c_side_out;
  logic           c_v;
  logic [31:0]    c_q;
  logic [30:0]    c_r;
  logic [19:0]    usec;
  assign c_side_in = '{a: r2_secs, b: '0, flag: 1'b0};

  wtt_div_pipe u_div_usec (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (r2_v),
    .rem_init (r2_frac[50:20]),
    .num      ({r2_frac[19:0], 12'd0}),
    .divisor  (rate_eff),
    .side_in  (c_side_in),
    .out_valid(c_v),
    .quot     (c_q),
    .rem      (c_r),
    .side_out (c_side_out)
  );

  assign usec = c_q[31:12];

  // output register with carry into seconds
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_v;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (usec >= wtt_pkg::UsecPerSec) begin
        seconds      <= c_side_out.a + 32'd1;
        microseconds <= usec - wtt_pkg::UsecPerSec;
      end else begin
        seconds      <= c_side_out.a;
        microseconds <= usec;
      end
    end
  end

endmodule

### design/wtt_div_pipe.sv
// pipelined restoring divider, one quotient bit per register stage
`timescale 1ns / 1ps

module wtt_div_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [wtt_pkg::RateW-1:0]      rem_init,
  input  logic [wtt_pkg::WordW-1:0]      num,
  input  logic [wtt_pkg::RateW-1:0]      divisor,
  input  wtt_pkg::side_t                 side_in,
  output logic                           out_valid,
  output logic [wtt_pkg::WordW-1:0]      quot,
  output logic [wtt_pkg::RateW-1:0]      rem,
  output wtt_pkg::side_t                 side_out
);

  logic                        v  [0:wtt_pkg::DivSteps];
  logic [wtt_pkg::RateW-1:0]   r  [0:wtt_pkg::DivSteps];
  logic [wtt_pkg::WordW-1:0]   nq [0:wtt_pkg::DivSteps];
  wtt_pkg::side_t              sd [0:wtt_pkg::DivSteps];

  assign v[0]  = in_valid;
  assign r[0]  = rem_init;
  assign nq[0] = num;
  assign sd[0] = side_in;

  for (genvar i = 0; i < wtt_pkg::DivSteps; i++) begin : g_step
    logic [wtt_pkg::WordW-1:0] shifted;
    logic [wtt_pkg::WordW-1:0] diff;
    logic                      ge;

    // partial remainder stays below the divisor, so the shift fits one word
    assign shifted = {r[i], nq[i][wtt_pkg::WordW-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign ge      = shifted >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r[i+1]  <= ge ? diff[wtt_pkg::RateW-1:0] : shifted[wtt_pkg::RateW-1:0];
        nq[i+1] <= {nq[i][wtt_pkg::WordW-2:0], ge};
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = v[wtt_pkg::DivSteps];
  assign quot      = nq[wtt_pkg::DivSteps];
  assign rem       = r[wtt_pkg::DivSteps];
  assign side_out  = sd[wtt_pkg::DivSteps];

endmodule

### design/wtt_checker.sv
// port-level checks for the wrapped tick to timeval converter
`timescale 1ns / 1ps

module wtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] seconds,
  input logic [19:0] microseconds
);

  a_usec_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> microseconds < wtt_pkg::UsecPerSec)
    else $error("microseconds out of range");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without an output stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(seconds) && $stable(microseconds)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind wrapped_ticks_to_timeval wtt_checker u_wtt_checker (
  .clk         (clk),
  .rst         (rst),
  .pready      (pready),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .seconds     (seconds),
  .microseconds(microseconds)
);

### sim/wrapped_ticks_to_timeval_tb.sv
// testbench for the wrapped tick to timeval converter with a self-checking scoreboard
`timescale 1ns / 1ps

class timeval_board;
  bit [31:0] rate;
  bit [31:0] exp_secs[$];
  bit [19:0] exp_usec[$];
  int errors;

  function new();
    rate = 32'd1000000;
    errors = 0;
  endfunction

  function void set_rate(bit [30:0] r);
    rate = {1'b0, r};
  endfunction

  // work out seconds and microseconds for an accepted transfer
  function void note_input(bit [31:0] ticks, bit [31:0] hint);
    bit [31:0] r, secs, delta, whole, rem, usec;
    bit [63:0] frac;
    r = (rate == 0) ? 32'd1 : rate;
    secs = hint;
    delta = ticks - secs * r;
    if (delta[31]) begin
      secs = secs - ((~delta) / r + 32'd1);
      delta = ticks - secs * r;
    end
    whole = delta / r;
    rem = delta % r;
    frac = 64'(rem) * 64'd1000000 + 64'(r / 2);
    usec = 32'(frac / 64'(r));
    secs = secs + whole;
    if (usec >= 32'd1000000) begin
      secs = secs + 1;
      usec = usec - 32'd1000000;
    end
    exp_secs.push_back(secs);
    exp_usec.push_back(usec[19:0]);
  endfunction

  function void check_result(bit [31:0] secs, bit [19:0] usec);
    bit [31:0] es;
    bit [19:0] eu;
    if (exp_secs.size() == 0) begin
      $error("result with nothing expected: seconds %0d microseconds %0d", secs, usec);
      errors++;
      return;
    end
    es = exp_secs.pop_front();
    eu = exp_usec.pop_front();
    if (secs !== es) begin
      $error("seconds: expected %0d actual %0d", es, secs);
      errors++;
    end
    if (usec !== eu) begin
      $error("microseconds: expected %0d actual %0d", eu, usec);
      errors++;
    end
  endfunction

  function int pending();
    return exp_secs.size();
  endfunction
endclass

module wrapped_ticks_to_timeval_tb;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [wtt_pkg::AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [31:0] tick_count, hint_seconds;
  logic out_valid, out_stall;
  logic [31:0] seconds;
  logic [19:0] microseconds;

  timeval_board board;
  bit sending_done;

  wrapped_ticks_to_timeval u_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic write_rate(bit [30:0] r);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {wtt_pkg::RegTickRate, 2'b00};
    pwdata <= {1'b0, r};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.set_rate(r);
  endtask

  // valid stays high after a transfer until the next gap or a drain
  task automatic send_time(bit [31:0] ticks, bit [31:0] hint);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    tick_count <= ticks;
    hint_seconds <= hint;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(ticks, hint);
  endtask

  // wait for the pipeline to drain before touching the register
  task automatic drain();
    in_valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // hint near the true time, so most items take the common path
  task automatic send_near(int n);
    bit [31:0] s, r, t;
    repeat (n) begin
      r = (board.rate == 0) ? 1 : board.rate;
      s = $urandom;
      t = s * r + $urandom_range(0, 3) * r + $urandom % r;
      case ($urandom_range(0, 3))
        0: send_time($urandom, $urandom);
        1: send_time(t, s + $urandom_range(0, 5));
        default: send_time(t, s + $urandom_range(0, 2));
      endcase
    end
  endtask

  // output side: random stall per result
  initial begin
    int hold;
    out_stall = 1;
    @(negedge rst);
    forever begin
      hold = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold != 0) begin
        out_stall <= 1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(seconds, microseconds);
    end
  end

  initial begin
    bit [30:0] rates[6];
    int timeout;
    board = new();
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; tick_count = 0; hint_seconds = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset rate, directed extremes
    send_time(32'd0, 32'd0);
    send_time(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_time(32'hFFFF_FFFF, 32'd0);
    send_time(32'd0, 32'hFFFF_FFFF);
    send_time(32'd999_999, 32'd0);
    send_time(32'd499_999, 32'd0);
    send_time(32'd999_500, 32'd4);
    send_time(32'h8000_0000, 32'd0);
    send_time(32'h7FFF_FFFF, 32'd2147);
    drain();

    rates = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd3, 31'd32768, 31'd90000};
    foreach (rates[i]) begin
      write_rate(rates[i]);
      send_time(32'd0, 32'd0);
      send_time(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_time(32'h8000_0000, 32'd1);
      send_near(60);
      drain();
    end

    write_rate(31'd1000000);
    send_near(300);
    drain();
    write_rate(31'($urandom_range(1, 32'h7FFF_FFFF)));
    send_near(300);
    drain();
    write_rate(31'($urandom_range(2, 2000)));
    send_near(150);
    in_valid <= 0;

    timeout = 0;
    while (board.pending() != 0 && timeout < 100000) begin
      @(posedge clk);
      timeout++;
    end
    repeat (120) @(posedge clk);
    if (board.pending() == 0 && board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

### filelist.f
design/wtt_pkg.sv
design/wtt_div_pipe.sv
design/wrapped_ticks_to_timeval.sv
design/wtt_checker.sv
sim/wrapped_ticks_to_timeval_tb.sv
